/* rtl/core/tint_pkg.sv */
// Shared types, constants and the arctangent table for the trajectory interpolator.
package tint_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int CORDIC_STEPS  = 20;
  localparam int HEADING_LIMIT = 23040;
  localparam int ACC_W         = 25;
  localparam int VEC_W         = 37;

  localparam logic [16:0] HALF_STEP_RESET = 17'd3277;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_LOAD    = 2'd1,
    FUNC_POS     = 2'd2,
    FUNC_HEADING = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] sample_or_query_time;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] heading;
    logic [10:0]        sample_count;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] ts;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } entry_t;

  typedef struct packed {
    logic               start;
    logic signed [32:0] dx;
    logic signed [32:0] dz;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] heading;
  } cordic_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_SCMP, S_SHRD, S_SHWR, S_WRNEW,
    S_PRD0, S_PRDL, S_PCL, S_PRD1, S_PRD0B, S_PCAP0,
    S_DIV, S_MUL, S_ADD, S_PEND, S_HSTART, S_HWAIT, S_DONE
  } seq_state_t;

  // atan(2^-i) in 1/32768 degree.
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd1474560;
      5'd1:  v = 22'd870484;
      5'd2:  v = 22'd459940;
      5'd3:  v = 22'd233473;
      5'd4:  v = 22'd117189;
      5'd5:  v = 22'd58652;
      5'd6:  v = 22'd29333;
      5'd7:  v = 22'd14667;
      5'd8:  v = 22'd7334;
      5'd9:  v = 22'd3667;
      5'd10: v = 22'd1833;
      5'd11: v = 22'd917;
      5'd12: v = 22'd458;
      5'd13: v = 22'd229;
      5'd14: v = 22'd115;
      5'd15: v = 22'd57;
      5'd16: v = 22'd29;
      5'd17: v = 22'd14;
      5'd18: v = 22'd7;
      5'd19: v = 22'd4;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/tint_mem.sv */
// Sample table storage: one write port and one registered read port.
module tint_mem #(
  parameter int DEPTH = tint_pkg::TABLE_DEPTH,
  parameter int AW    = $clog2(tint_pkg::TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tint_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output tint_pkg::entry_t rdata
);

  tint_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tint_cordic.sv */
// Iterative vectoring CORDIC that turns a horizontal move into a heading.
module tint_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tint_pkg::cordic_req_t req,
  output tint_pkg::cordic_rsp_t rsp
);

  localparam int VW = tint_pkg::VEC_W;
  localparam int AC = tint_pkg::ACC_W;
  localparam logic signed [AC-1:0] QUARTER = AC'(90 * 32768);
  localparam logic signed [16:0]   LIMIT   = 17'(tint_pkg::HEADING_LIMIT);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           i_r, i_nxt;
  logic signed [VW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AC-1:0] acc_r, acc_nxt;
  logic signed [15:0]   hd_r, hd_nxt;

  logic signed [VW-1:0] x0, y0, xs, ys;
  logic signed [3:0]    dx4, dz4;
  logic signed [7:0]    sq_sum;
  logic                 tiny;
  logic signed [AC-1:0] acc_step, acc_rnd;
  logic signed [16:0]   h_full;
  logic signed [AC-1:0] ang;

  always_comb begin
    x0  = {{(VW-33){req.dx[32]}}, req.dx};
    y0  = -{{(VW-33){req.dz[32]}}, req.dz};
    dx4 = req.dx[3:0];
    dz4 = req.dz[3:0];
    sq_sum = 8'(dx4 * dx4) + 8'(dz4 * dz4);
    tiny = (req.dx > -33'sd7) && (req.dx < 33'sd7) &&
           (req.dz > -33'sd7) && (req.dz < 33'sd7) && (sq_sum < 8'sd43);
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    ang = $signed({{(AC-22){1'b0}}, tint_pkg::atan_entry(i_r)});
    acc_step = y_r[VW-1] ? acc_r - ang : acc_r + ang;
    acc_rnd  = acc_step + AC'(128);
    h_full   = 17'(acc_rnd >>> 8);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    hd_nxt   = hd_r;

    if (!busy_r) begin
      if (req.start) begin
        if (tiny) begin
          hd_nxt   = '0;
          done_nxt = 1'b1;
        end else begin
          busy_nxt = 1'b1;
          i_nxt    = '0;
          if (x0[VW-1]) begin
            if (!y0[VW-1]) begin
              x_nxt = y0;  y_nxt = -x0; acc_nxt = QUARTER;
            end else begin
              x_nxt = -y0; y_nxt = x0;  acc_nxt = -QUARTER;
            end
          end else begin
            x_nxt = x0; y_nxt = y0; acc_nxt = '0;
          end
        end
      end
    end else begin
      if (!y_r[VW-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
      end
      acc_nxt = acc_step;
      i_nxt   = i_r + 5'd1;
      if (i_r == 5'(tint_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (h_full > LIMIT) begin
          hd_nxt = 16'(LIMIT);
        end else if (h_full < -LIMIT) begin
          hd_nxt = 16'(-LIMIT);
        end else begin
          hd_nxt = h_full[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    hd_r  <= hd_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.heading = hd_r;

endmodule

/* rtl/core/trajectory_interpolator.sv */
// Top level: sorted sample table with position and heading interpolation.
// Clear, full-table loads and empty-table queries go straight to the output state.
// A load binary-searches for its slot and shifts the entries after that slot up by one.
// A position query binary-searches the table and interpolates; a heading query runs three
// position lookups and a 20-step CORDIC.
// One item is worked at a time; search, 17-step divide and shifts share one datapath.
// Reset empties the table and sets the heading half-step to 0.05 s; table memory is not cleared.
module trajectory_interpolator #(
  parameter int TABLE_DEPTH = tint_pkg::TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tint_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tint_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  tint_pkg::seq_state_t state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [16:0]        half_r;
  tint_pkg::func_t    func_r, func_nxt;
  logic signed [31:0] key_r, key_nxt, qt_r, qt_nxt;
  tint_pkg::entry_t   newe_r, newe_nxt;
  logic [CW-1:0]      lo_r, lo_nxt, hi_r, hi_nxt, ptr_r, ptr_nxt;
  logic [AW-1:0]      mid_r, mid_nxt;
  tint_pkg::entry_t   first_r, first_nxt, last_r, last_nxt, e0_r, e0_nxt, e1_r, e1_nxt;
  logic [1:0]         phase_r, phase_nxt, axis_r, axis_nxt;
  logic [32:0]        rem_r, rem_nxt, span_r, span_nxt;
  logic [16:0]        alpha_r, alpha_nxt;
  logic [4:0]         bit_r, bit_nxt;
  logic signed [50:0] prod_r, prod_nxt;
  logic signed [31:0] cur_r [3];
  logic signed [31:0] cur_nxt [3];
  logic signed [31:0] pos_r [3];
  logic signed [31:0] pos_nxt [3];
  logic signed [31:0] pax_r, pax_nxt, paz_r, paz_nxt;
  logic signed [15:0] hd_r, hd_nxt;
  logic [1:0]         status_r, status_nxt;
  tint_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  tint_pkg::entry_t   mem_wdata, rd_e;

  tint_pkg::cordic_req_t creq;
  tint_pkg::cordic_rsp_t crsp;

  logic [CW-1:0]      mid_full;
  logic               go_right, rem_ge;
  logic [32:0]        rem_sub;
  logic signed [31:0] lerp_a, lerp_b;
  logic signed [32:0] lerp_d;
  logic signed [50:0] lerp_sum;
  logic signed [33:0] t_ext;

  tint_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_e)
  );

  tint_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  always_comb begin
    mid_full = lo_r + ((hi_r - lo_r) >> 1);
    // Loads go after equal times; queries stop at the first time not below the key.
    go_right = (func_r == tint_pkg::FUNC_LOAD) ? (rd_e.ts <= key_r) : (rd_e.ts < key_r);
    rem_ge   = rem_r >= span_r;
    rem_sub  = rem_ge ? rem_r - span_r : rem_r;
    case (axis_r)
      2'd0:    begin lerp_a = e0_r.px; lerp_b = e1_r.px; end
      2'd1:    begin lerp_a = e0_r.py; lerp_b = e1_r.py; end
      default: begin lerp_a = e0_r.pz; lerp_b = e1_r.pz; end
    endcase
    lerp_d   = {lerp_b[31], lerp_b} - {lerp_a[31], lerp_a};
    lerp_sum = {{19{lerp_a[31]}}, lerp_a} + (prod_r >>> 16);
    t_ext    = '0;

    state_nxt = state_r;
    count_nxt = count_r;
    func_nxt  = func_r;
    key_nxt   = key_r;
    qt_nxt    = qt_r;
    newe_nxt  = newe_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    ptr_nxt   = ptr_r;
    mid_nxt   = mid_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    e0_nxt    = e0_r;
    e1_nxt    = e1_r;
    phase_nxt = phase_r;
    axis_nxt  = axis_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    alpha_nxt = alpha_r;
    bit_nxt   = bit_r;
    prod_nxt  = prod_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    pax_nxt   = pax_r;
    paz_nxt   = paz_r;
    hd_nxt    = hd_r;
    status_nxt = status_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    in_stall  = (state_r != tint_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = ptr_r[AW-1:0];
    mem_wdata = rd_e;
    mem_raddr = mid_r;
    creq.start = 1'b0;
    creq.dx    = {cur_r[0][31], cur_r[0]} - {pax_r[31], pax_r};
    creq.dz    = {cur_r[2][31], cur_r[2]} - {paz_r[31], paz_r};

    case (state_r)
      tint_pkg::S_IDLE: begin
        if (in_valid) begin
          func_nxt   = tint_pkg::func_t'(in_item.func);
          key_nxt    = in_item.sample_or_query_time;
          qt_nxt     = in_item.sample_or_query_time;
          newe_nxt   = '{ts: in_item.sample_or_query_time, px: in_item.load_x,
                         py: in_item.load_y, pz: in_item.load_z};
          pos_nxt    = '{default: '0};
          hd_nxt     = '0;
          status_nxt = tint_pkg::STATUS_OK;
          phase_nxt  = '0;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          case (tint_pkg::func_t'(in_item.func))
            tint_pkg::FUNC_CLEAR: begin
              count_nxt = '0;
              state_nxt = tint_pkg::S_DONE;
            end
            tint_pkg::FUNC_LOAD: begin
              if (count_r >= CW'(TABLE_DEPTH)) begin
                status_nxt = tint_pkg::STATUS_FULL;
                state_nxt  = tint_pkg::S_DONE;
              end else begin
                state_nxt = tint_pkg::S_SRCH;
              end
            end
            default: begin
              if (count_r == '0) begin
                status_nxt = tint_pkg::STATUS_EMPTY;
                state_nxt  = tint_pkg::S_DONE;
              end else begin
                state_nxt = tint_pkg::S_PRD0;
              end
            end
          endcase
        end
      end

      tint_pkg::S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_full[AW-1:0];
          mem_raddr = mid_full[AW-1:0];
          state_nxt = tint_pkg::S_SCMP;
        end else if (func_r == tint_pkg::FUNC_LOAD) begin
          ptr_nxt   = count_r;
          state_nxt = tint_pkg::S_SHRD;
        end else begin
          state_nxt = tint_pkg::S_PRD1;
        end
      end

      tint_pkg::S_SCMP: begin
        // The read of mid_r was issued in the previous cycle and lands now.
        mem_raddr = mid_r;
        if (go_right) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
        state_nxt = tint_pkg::S_SRCH;
      end

      tint_pkg::S_SHRD: begin
        if (ptr_r == lo_r) begin
          state_nxt = tint_pkg::S_WRNEW;
        end else begin
          mem_raddr = AW'(ptr_r - CW'(1));
          state_nxt = tint_pkg::S_SHWR;
        end
      end

      tint_pkg::S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = rd_e;
        ptr_nxt   = ptr_r - CW'(1);
        state_nxt = tint_pkg::S_SHRD;
      end

      tint_pkg::S_WRNEW: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r[AW-1:0];
        mem_wdata = newe_r;
        count_nxt = count_r + CW'(1);
        state_nxt = tint_pkg::S_DONE;
      end

      tint_pkg::S_PRD0: begin
        mem_raddr = '0;
        state_nxt = tint_pkg::S_PRDL;
      end

      tint_pkg::S_PRDL: begin
        first_nxt = rd_e;
        mem_raddr = AW'(count_r - CW'(1));
        state_nxt = tint_pkg::S_PCL;
      end

      tint_pkg::S_PCL: begin
        last_nxt = rd_e;
        lo_nxt   = '0;
        hi_nxt   = count_r;
        if (key_r <= first_r.ts) begin
          cur_nxt   = '{first_r.px, first_r.py, first_r.pz};
          state_nxt = tint_pkg::S_PEND;
        end else if (key_r >= rd_e.ts) begin
          cur_nxt   = '{rd_e.px, rd_e.py, rd_e.pz};
          state_nxt = tint_pkg::S_PEND;
        end else begin
          state_nxt = tint_pkg::S_SRCH;
        end
      end

      tint_pkg::S_PRD1: begin
        mem_raddr = lo_r[AW-1:0];
        state_nxt = tint_pkg::S_PRD0B;
      end

      tint_pkg::S_PRD0B: begin
        e1_nxt    = rd_e;
        mem_raddr = AW'(lo_r - CW'(1));
        state_nxt = tint_pkg::S_PCAP0;
      end

      tint_pkg::S_PCAP0: begin
        e0_nxt    = rd_e;
        rem_nxt   = 33'({key_r[31], key_r} - {rd_e.ts[31], rd_e.ts});
        span_nxt  = 33'({e1_r.ts[31], e1_r.ts} - {rd_e.ts[31], rd_e.ts});
        alpha_nxt = '0;
        bit_nxt   = 5'd16;
        state_nxt = tint_pkg::S_DIV;
      end

      tint_pkg::S_DIV: begin
        // Restoring division of (t - t0) * 65536 by the span, one quotient bit a cycle.
        alpha_nxt = {alpha_r[15:0], rem_ge};
        rem_nxt   = {rem_sub[31:0], 1'b0};
        if (bit_r == 5'd0) begin
          axis_nxt  = '0;
          state_nxt = tint_pkg::S_MUL;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end

      tint_pkg::S_MUL: begin
        prod_nxt  = 51'(lerp_d) * $signed({34'd0, alpha_r});
        state_nxt = tint_pkg::S_ADD;
      end

      tint_pkg::S_ADD: begin
        cur_nxt[axis_r] = lerp_sum[31:0];
        if (axis_r == 2'd2) begin
          state_nxt = tint_pkg::S_PEND;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = tint_pkg::S_MUL;
        end
      end

      tint_pkg::S_PEND: begin
        case (phase_r)
          2'd0: begin
            pos_nxt = cur_r;
            if (func_r == tint_pkg::FUNC_HEADING) begin
              t_ext = {{2{qt_r[31]}}, qt_r} - {17'd0, half_r};
              key_nxt = (t_ext < $signed({{2{first_r.ts[31]}}, first_r.ts})) ?
                        first_r.ts : t_ext[31:0];
              phase_nxt = 2'd1;
              state_nxt = tint_pkg::S_PRD0;
            end else begin
              state_nxt = tint_pkg::S_DONE;
            end
          end
          2'd1: begin
            pax_nxt = cur_r[0];
            paz_nxt = cur_r[2];
            t_ext = {{2{qt_r[31]}}, qt_r} + {17'd0, half_r};
            key_nxt = (t_ext > $signed({{2{last_r.ts[31]}}, last_r.ts})) ?
                      last_r.ts : t_ext[31:0];
            phase_nxt = 2'd2;
            state_nxt = tint_pkg::S_PRD0;
          end
          default: begin
            state_nxt = tint_pkg::S_HSTART;
          end
        endcase
      end

      tint_pkg::S_HSTART: begin
        creq.start = 1'b1;
        state_nxt  = tint_pkg::S_HWAIT;
      end

      tint_pkg::S_HWAIT: begin
        if (crsp.done) begin
          hd_nxt    = crsp.heading;
          state_nxt = tint_pkg::S_DONE;
        end
      end

      tint_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = '{pos_x: pos_r[0], pos_y: pos_r[1], pos_z: pos_r[2],
                      heading: hd_r, sample_count: 11'(count_r), status: status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = tint_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = tint_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tint_pkg::S_IDLE;
      count_r     <= '0;
      half_r      <= tint_pkg::HALF_STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        half_r <= cfg_wdata;
      end
    end
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    qt_r     <= qt_nxt;
    newe_r   <= newe_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    ptr_r    <= ptr_nxt;
    mid_r    <= mid_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    e0_r     <= e0_nxt;
    e1_r     <= e1_nxt;
    phase_r  <= phase_nxt;
    axis_r   <= axis_nxt;
    rem_r    <= rem_nxt;
    span_r   <= span_nxt;
    alpha_r  <= alpha_nxt;
    bit_r    <= bit_nxt;
    prod_r   <= prod_nxt;
    cur_r    <= cur_nxt;
    pos_r    <= pos_nxt;
    pax_r    <= pax_nxt;
    paz_r    <= paz_nxt;
    hd_r     <= hd_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
